// ----- rtl/core/cds_pkg.sv -----
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants for the calendar date shift unit
// Field widths, command codes, year counter operations and the
// days-in-month lookup used by the sequencer.
// ----------------------------------------------------------------------------
package cds_pkg;

  // field widths
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int DeltaW  = 9;
  localparam int CmdW    = 2;
  localparam int CentW   = 7;

  // packed stream widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 40;

  // largest accepted day delta
  localparam int MaxDayDelta = 255;

  // year / 100 by reciprocal multiplication, exact for years below 43699
  localparam logic [12:0] DivRecip = 13'd5243;
  localparam int          DivShift = 19;

  // narrow signed word used by the shared adder
  typedef logic signed [7:0] small_t;

  // unit of the delta
  typedef enum logic [CmdW-1:0] {
    CMD_HOURS  = 2'd0,
    CMD_DAYS   = 2'd1,
    CMD_MONTHS = 2'd2
  } cmd_e;

  // year counter operations
  typedef enum logic [2:0] {
    YR_HOLD,
    YR_SPLIT_HI,
    YR_SPLIT_LO,
    YR_INC,
    YR_DEC,
    YR_MERGE
  } yr_op_e;

  // year counter status
  typedef struct packed {
    logic             leap;
    logic             under;
    logic             over;
    logic [YearW-1:0] year;
  } yr_stat_t;

  // shared adder request and response
  typedef struct packed {
    small_t a;
    small_t b;
    small_t lo;
    small_t hi;
  } alu_req_t;

  typedef struct packed {
    small_t sum;
    logic   below;
    logic   above;
  } alu_rsp_t;

  // gregorian days in month, leap flag supplied by the year counter
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/cds_day_alu.sv -----
// ----------------------------------------------------------------------------
// cds_day_alu: shared add and range compare unit
// One narrow signed add with a compare of the sum against a lower and an
// upper bound; reused by every hour, day and month step of the sequencer.
// ----------------------------------------------------------------------------
module cds_day_alu (
  input  cds_pkg::alu_req_t req_i,
  output cds_pkg::alu_rsp_t rsp_o
);
  import cds_pkg::*;

  small_t sum;

  // add and compare against both bounds
  assign sum         = $signed(req_i.a) + $signed(req_i.b);
  assign rsp_o.sum   = sum;
  assign rsp_o.below = sum < $signed(req_i.lo);
  assign rsp_o.above = sum > $signed(req_i.hi);

endmodule

// ----- rtl/core/cds_year_unit.sv -----
// ----------------------------------------------------------------------------
// cds_year_unit: year held as century and year of century
// Splits the incoming year in two steps, steps it by one year either
// way, gives the leap flag and merges it back into a binary year.
// ----------------------------------------------------------------------------
module cds_year_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [cds_pkg::YearW-1:0]       year_i,
  input  cds_pkg::yr_op_e                 op_i,
  output cds_pkg::yr_stat_t               stat_o
);
  import cds_pkg::*;

  localparam logic [CentW-1:0] LastYy   = 7'd99;
  localparam logic [CentW-1:0] Century  = 7'd100;

  logic [CentW-1:0]   cent_q, cent_d;
  logic [CentW-1:0]   yy_q, yy_d;
  logic               under_q, under_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [26:0]        prod;
  logic [YearW-1:0]   cent_x100;

  // reciprocal product for the century and its scaled value
  assign prod      = 27'(year_i) * 27'(DivRecip);
  assign cent_x100 = YearW'(cent_q) * YearW'(Century);

  // counter operations
  always_comb begin
    cent_d  = cent_q;
    yy_d    = yy_q;
    under_d = under_q;
    year_d  = year_q;
    case (op_i)
      YR_SPLIT_HI: begin
        cent_d = prod[DivShift +: CentW];
      end
      YR_SPLIT_LO: begin
        yy_d    = CentW'(year_i - cent_x100);
        under_d = 1'b0;
      end
      YR_INC: begin
        if (yy_q == LastYy) begin
          yy_d   = '0;
          cent_d = cent_q + 7'd1;
        end else begin
          yy_d = yy_q + 7'd1;
        end
      end
      YR_DEC: begin
        if (yy_q == '0) begin
          yy_d = LastYy;
          if (cent_q == '0) begin
            under_d = 1'b1;
          end else begin
            cent_d = cent_q - 7'd1;
          end
        end else begin
          yy_d = yy_q - 7'd1;
        end
      end
      YR_MERGE: begin
        year_d = cent_x100 + YearW'(yy_q);
      end
      default: begin
      end
    endcase
  end

  // year registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      under_q <= 1'b0;
    end else begin
      under_q <= under_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cent_q <= cent_d;
    yy_q   <= yy_d;
    year_q <= year_d;
  end

  // status towards the sequencer
  assign stat_o.leap  = (yy_q[1:0] == 2'b00) && ((yy_q != '0) || (cent_q[1:0] == 2'b00));
  assign stat_o.under = under_q;
  assign stat_o.over  = (cent_q >= Century);
  assign stat_o.year  = year_q;

endmodule

// ----- rtl/core/calendar_date_shift_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_date_shift_unit: adds an hour, day or month delta to a timestamp
// A small sequencer drives one shared add/compare unit and a century based
// year counter; forward days go ten at a time, backward days in one chunk, with month carry and borrow.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                                   tuser
//  s_axis    in         year month day hour minute second delta command
//  m_axis    out        year month day hour minute second       range_error
//
//  An accepted item first has its year split into century and year of
//  century, then the shared adder steps the fields; a day chunk adds a
//  borrow or carry pair of steps per month crossing, and a rejected
//  item goes straight to the result register.
//  Input is taken only while the sequencer is idle; a finished result waits
//  in the output register and the next item may already start meanwhile.
//  Reset clears the sequencer and the output valid flag.
//
module calendar_date_shift_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // year, month, day, hour, minute, second, delta (from bit 0 up)
  input  logic [cds_pkg::InDataW-1:0]    s_axis_tdata_i,
  // command
  input  logic [cds_pkg::CmdW-1:0]       s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // year, month, day, hour, minute, second (from bit 0 up)
  output logic [cds_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // range_error
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import cds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT_HI,
    ST_SPLIT_LO,
    ST_H_ADD,
    ST_H_FIX,
    ST_D_STEP,
    ST_D_BORROW,
    ST_D_BFIX,
    ST_D_CARRY,
    ST_D_CINC,
    ST_M_ADD,
    ST_M_FIX,
    ST_MERGE,
    ST_DONE
  } state_e;

  // input fields
  logic [YearW-1:0]          in_year;
  logic [MonthW-1:0]         in_month;
  logic [DayW-1:0]           in_day;
  logic [HourW-1:0]          in_hour;
  logic [MinW-1:0]           in_min;
  logic [SecW-1:0]           in_sec;
  logic signed [DeltaW-1:0]  in_delta;
  cmd_e                      in_cmd;
  logic                      stamp_bad, delta_bad, in_bad;

  // sequencer state and working registers
  state_e                    state_q, state_d;
  cmd_e                      cmd_q, cmd_d;
  logic [YearW-1:0]          year_q, year_d;
  logic [MonthW-1:0]         orig_month_q, orig_month_d;
  logic [DayW-1:0]           orig_day_q, orig_day_d;
  logic [HourW-1:0]          orig_hour_q, orig_hour_d;
  logic [MinW-1:0]           min_q, min_d;
  logic [SecW-1:0]           sec_q, sec_d;
  logic signed [DeltaW-1:0]  delta_q, delta_d;
  logic                      err_q, err_d;
  logic [MonthW-1:0]         month_q, month_d;
  small_t                    day_q, day_d;
  small_t                    hour_q, hour_d;
  logic signed [DeltaW-1:0]  rem_q, rem_d;
  logic                      last_q, last_d;

  // output register
  logic [OutDataW-1:0]       m_tdata_q, m_tdata_d;
  logic                      m_tuser_q, m_tuser_d;
  logic                      m_tvalid_q, m_tvalid_d;

  // shared units
  alu_req_t                  alu_req;
  alu_rsp_t                  alu_rsp;
  yr_op_e                    yr_op;
  yr_stat_t                  yr_stat;
  small_t                    ml_s;
  small_t                    chunk;
  logic                      rem_big;
  logic                      out_free;
  logic                      err_fin;

  // unpack the input transaction
  assign in_year  = s_axis_tdata_i[13:0];
  assign in_month = s_axis_tdata_i[17:14];
  assign in_day   = s_axis_tdata_i[22:18];
  assign in_hour  = s_axis_tdata_i[27:23];
  assign in_min   = s_axis_tdata_i[33:28];
  assign in_sec   = s_axis_tdata_i[39:34];
  assign in_delta = $signed(s_axis_tdata_i[48:40]);
  assign in_cmd   = cmd_e'(s_axis_tuser_i);

  // request checks
  assign stamp_bad = (in_year > 14'd9999) || (in_month == '0) || (in_month > 4'd12) ||
                     (in_day == '0) || (in_hour > 5'd23);

  always_comb begin
    case (in_cmd)
      CMD_HOURS:  delta_bad = (in_delta < -9'sd23) || (in_delta > 9'sd23);
      CMD_DAYS:   delta_bad = (in_delta < -9'sd27) || (int'(in_delta) > MaxDayDelta);
      CMD_MONTHS: delta_bad = (in_delta < -9'sd11) || (in_delta > 9'sd11);
      default:    delta_bad = 1'b1;
    endcase
  end

  assign in_bad = stamp_bad || delta_bad;

  // day chunk and month length for the current date
  assign rem_big = rem_q > 9'sd10;
  assign chunk   = rem_big ? 8'sd10 : small_t'(rem_q[7:0]);
  assign ml_s    = small_t'({3'b000, month_len(month_q, yr_stat.leap)});

  assign out_free = !m_tvalid_q || m_axis_tready_i;
  assign err_fin  = err_q || yr_stat.under || yr_stat.over;

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    year_d       = year_q;
    orig_month_d = orig_month_q;
    orig_day_d   = orig_day_q;
    orig_hour_d  = orig_hour_q;
    min_d        = min_q;
    sec_d        = sec_q;
    delta_d      = delta_q;
    err_d        = err_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    rem_d        = rem_q;
    last_d       = last_q;
    m_tdata_d    = m_tdata_q;
    m_tuser_d    = m_tuser_q;
    m_tvalid_d   = m_tvalid_q;
    yr_op        = YR_HOLD;
    alu_req      = '{a: day_q, b: chunk, lo: 8'sd1, hi: ml_s};

    // output transaction taken
    if (m_tvalid_q && m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d        = in_cmd;
          year_d       = in_year;
          orig_month_d = in_month;
          orig_day_d   = in_day;
          orig_hour_d  = in_hour;
          min_d        = in_min;
          sec_d        = in_sec;
          delta_d      = in_delta;
          err_d        = in_bad;
          month_d      = in_month;
          day_d        = small_t'({3'b000, in_day});
          hour_d       = small_t'({3'b000, in_hour});
          state_d      = in_bad ? ST_DONE : ST_SPLIT_HI;
        end
      end
      ST_SPLIT_HI: begin
        yr_op   = YR_SPLIT_HI;
        state_d = ST_SPLIT_LO;
      end
      ST_SPLIT_LO: begin
        yr_op = YR_SPLIT_LO;
        rem_d = delta_q;
        case (cmd_q)
          CMD_HOURS: state_d = ST_H_ADD;
          CMD_DAYS:  state_d = ST_D_STEP;
          default:   state_d = ST_M_ADD;
        endcase
      end
      // hour add, wrap moves the day by one
      ST_H_ADD: begin
        alu_req = '{a: hour_q, b: small_t'(delta_q[7:0]), lo: 8'sd0, hi: 8'sd23};
        hour_d  = alu_rsp.sum;
        if (alu_rsp.below) begin
          rem_d   = -9'sd1;
          state_d = ST_H_FIX;
        end else if (alu_rsp.above) begin
          rem_d   = 9'sd1;
          state_d = ST_H_FIX;
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_H_FIX: begin
        alu_req = '{a: hour_q, b: (rem_q[DeltaW-1] ? 8'sd24 : -8'sd24),
                    lo: 8'sd0, hi: 8'sd23};
        hour_d  = alu_rsp.sum;
        state_d = ST_D_STEP;
      end
      // one day chunk: at most ten days forward, or the whole backward delta
      ST_D_STEP: begin
        alu_req = '{a: day_q, b: chunk, lo: 8'sd1, hi: ml_s};
        day_d   = alu_rsp.sum;
        last_d  = !rem_big;
        rem_d   = rem_q - 9'sd10;
        if (alu_rsp.below) begin
          state_d = ST_D_BORROW;
        end else if (alu_rsp.above) begin
          state_d = ST_D_CARRY;
        end else begin
          state_d = rem_big ? ST_D_STEP : ST_MERGE;
        end
      end
      // borrow: previous month, then add its length
      ST_D_BORROW: begin
        alu_req = '{a: small_t'({4'b0000, month_q}), b: -8'sd1, lo: 8'sd1, hi: 8'sd12};
        if (alu_rsp.below) begin
          month_d = 4'd12;
          yr_op   = YR_DEC;
        end else begin
          month_d = alu_rsp.sum[3:0];
        end
        state_d = ST_D_BFIX;
      end
      ST_D_BFIX: begin
        alu_req = '{a: day_q, b: ml_s, lo: 8'sd1, hi: ml_s};
        day_d   = alu_rsp.sum;
        state_d = last_q ? ST_MERGE : ST_D_STEP;
      end
      // carry: drop this month's length, then next month
      ST_D_CARRY: begin
        alu_req = '{a: day_q, b: -ml_s, lo: 8'sd1, hi: ml_s};
        day_d   = alu_rsp.sum;
        state_d = ST_D_CINC;
      end
      ST_D_CINC: begin
        alu_req = '{a: small_t'({4'b0000, month_q}), b: 8'sd1, lo: 8'sd1, hi: 8'sd12};
        if (alu_rsp.above) begin
          month_d = 4'd1;
          yr_op   = YR_INC;
        end else begin
          month_d = alu_rsp.sum[3:0];
        end
        state_d = last_q ? ST_MERGE : ST_D_STEP;
      end
      // month add, wrap carries into the year
      ST_M_ADD: begin
        alu_req = '{a: small_t'({4'b0000, month_q}), b: small_t'(delta_q[7:0]),
                    lo: 8'sd1, hi: 8'sd12};
        month_d = alu_rsp.sum[3:0];
        if (alu_rsp.below) begin
          yr_op   = YR_DEC;
          state_d = ST_M_FIX;
        end else if (alu_rsp.above) begin
          yr_op   = YR_INC;
          state_d = ST_M_FIX;
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_M_FIX: begin
        alu_req = '{a: small_t'({4'b0000, month_q}),
                    b: (delta_q[DeltaW-1] ? 8'sd12 : -8'sd12), lo: 8'sd1, hi: 8'sd12};
        month_d = alu_rsp.sum[3:0];
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        yr_op   = YR_MERGE;
        state_d = ST_DONE;
      end
      // load the result register once it is free
      ST_DONE: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tuser_d  = err_fin;
          if (err_fin) begin
            m_tdata_d = {sec_q, min_q, orig_hour_q, orig_day_q, orig_month_q, year_q};
          end else begin
            m_tdata_d = {sec_q, min_q, hour_q[HourW-1:0], day_q[DayW-1:0], month_q,
                         yr_stat.year};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    year_q       <= year_d;
    orig_month_q <= orig_month_d;
    orig_day_q   <= orig_day_d;
    orig_hour_q  <= orig_hour_d;
    min_q        <= min_d;
    sec_q        <= sec_d;
    delta_q      <= delta_d;
    err_q        <= err_d;
    month_q      <= month_d;
    day_q        <= day_d;
    hour_q       <= hour_d;
    rem_q        <= rem_d;
    last_q       <= last_d;
    m_tdata_q    <= m_tdata_d;
    m_tuser_q    <= m_tuser_d;
  end

  // shared adder
  cds_day_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // year counter
  cds_year_unit u_year (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .year_i (year_q),
    .op_i   (yr_op),
    .stat_o (yr_stat)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;
  assign m_axis_tvalid_o = m_tvalid_q;

  // day stays within 1..31 before each day chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D_STEP) |-> (day_q >= 8'sd1 && day_q <= 8'sd31))
    else $error("day out of 1..31 before a day chunk");

  // month stays 1..12 between chunks and the request was accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D_STEP) |-> (month_q >= 4'd1 && month_q <= 4'd12 && !err_q))
    else $error("month out of range or rejected request in day stepping");

  // hour wrapped back into 0..23 before the year merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (hour_q >= 8'sd0 && hour_q <= 8'sd23))
    else $error("hour out of range at merge");

  // a finished result reaches the output and frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_axis_tvalid_o && s_axis_tready_o))
    else $error("result not presented after completion");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream level test of calendar_date_shift_unit
// Drives timestamps with hour, day and month deltas through the input
// stream, predicts each shifted timestamp and range flag in a local
// calendar model, and compares every output transaction in order. Phases
// vary sender gaps and receiver stalls, and one holds the output off long
// enough to back the input up.
// ----------------------------------------------------------------------------
module testbench;
  import cds_pkg::*;

  // command code with no meaning in the block
  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;
  localparam int PhaseItems = 265;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles = 100;

  // one requested shift
  typedef struct {
    logic [CmdW-1:0]   command;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic [DeltaW-1:0] delta;
  } shift_req_t;

  // one shifted timestamp as the block should return it
  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic              range_error;
  } shifted_stamp_t;

  // working calendar fields, wide enough to leave range
  typedef struct {
    int year;
    int month;
    int day;
    int hour;
  } calendar_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  // year, month, day, hour, minute, second, delta (from bit 0 up)
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  // command
  logic [CmdW-1:0]     s_axis_tuser_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // year, month, day, hour, minute, second (from bit 0 up)
  logic [OutDataW-1:0] m_axis_tdata_o;
  // range_error
  logic                m_axis_tuser_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  shifted_stamp_t pending_stamps[$];
  int             fail_count = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_off_len = 0;
  int             hold_off_seq = 0;
  int             hold_off_seen = 0;
  int             hold_off_left = 0;

  calendar_date_shift_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // gregorian month length, year 0 counts as leap
  function automatic int days_in_month(int m, int y);
    if (m == 2) begin
      return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // month add with a single wrap into the year
  function automatic void roll_month(inout calendar_t c, input int d);
    c.month += d;
    if (c.month < 1) begin
      c.month += 12;
      c.year -= 1;
    end else if (c.month > 12) begin
      c.month -= 12;
      c.year += 1;
    end
  endfunction

  // one day chunk, wrapping at most once across a month end
  function automatic void step_days(inout calendar_t c, input int d);
    c.day += d;
    if (c.day < 1) begin
      roll_month(c, -1);
      c.day += days_in_month(c.month, c.year);
    end else if (c.day > days_in_month(c.month, c.year)) begin
      c.day -= days_in_month(c.month, c.year);
      roll_month(c, 1);
    end
  endfunction

  // day add in forward chunks of at most ten, a backward delta in one chunk
  function automatic void add_days(inout calendar_t c, input int d);
    int rest;
    rest = d;
    while (rest > 10) begin
      step_days(c, 10);
      rest -= 10;
    end
    step_days(c, rest);
  endfunction

  // hour add, carrying a single day
  function automatic void add_hours(inout calendar_t c, input int d);
    c.hour += d;
    if (c.hour < 0) begin
      c.hour += 24;
      add_days(c, -1);
    end else if (c.hour > 23) begin
      c.hour -= 24;
      add_days(c, 1);
    end
  endfunction

  // expected result of one request
  function automatic shifted_stamp_t shift_stamp(shift_req_t r);
    calendar_t      orig;
    calendar_t      c;
    int             delta;
    logic           err;
    shifted_stamp_t res;
    orig.year = r.year;
    orig.month = r.month;
    orig.day = r.day;
    orig.hour = r.hour;
    delta = int'($signed(r.delta));
    err = 1'b0;
    c = orig;
    if (orig.year > 9999 || orig.month < 1 || orig.month > 12 || orig.day < 1 ||
        orig.hour > 23) begin
      err = 1'b1;
    end else if (r.command == CMD_HOURS) begin
      if (delta < -23 || delta > 23) err = 1'b1;
      else add_hours(c, delta);
    end else if (r.command == CMD_DAYS) begin
      if (delta < -27 || delta > MaxDayDelta) err = 1'b1;
      else add_days(c, delta);
    end else if (r.command == CMD_MONTHS) begin
      if (delta < -11 || delta > 11) err = 1'b1;
      else roll_month(c, delta);
    end else begin
      err = 1'b1;
    end
    if (!err && (c.year < 0 || c.year > 9999)) err = 1'b1;
    if (err) c = orig;
    res.year = YearW'(c.year);
    res.month = MonthW'(c.month);
    res.day = DayW'(c.day);
    res.hour = HourW'(c.hour);
    res.minute = r.minute;
    res.second = r.second;
    res.range_error = err;
    return res;
  endfunction

  function automatic shift_req_t make_req(logic [CmdW-1:0] cmd, int y, int m, int d,
                                          int h, int mi, int s, int delta);
    shift_req_t r;
    r.command = cmd;
    r.year = YearW'(y);
    r.month = MonthW'(m);
    r.day = DayW'(d);
    r.hour = HourW'(h);
    r.minute = MinW'(mi);
    r.second = SecW'(s);
    r.delta = DeltaW'(delta);
    return r;
  endfunction

  // random request: mostly well-formed, some raw noise
  function automatic shift_req_t random_req();
    shift_req_t r;
    int         pick;
    if ($urandom_range(0, 99) < 8) begin
      r.command = CmdW'($urandom_range(0, 3));
      r.year = YearW'($urandom);
      r.month = MonthW'($urandom);
      r.day = DayW'($urandom);
      r.hour = HourW'($urandom);
      r.minute = MinW'($urandom);
      r.second = SecW'($urandom);
      r.delta = DeltaW'($urandom);
      return r;
    end
    case ($urandom_range(0, 3))
      0: r.year = YearW'($urandom_range(0, 3));
      1: r.year = YearW'($urandom_range(9996, 9999));
      default: r.year = YearW'($urandom_range(0, 9999));
    endcase
    r.month = MonthW'($urandom_range(1, 12));
    r.day = DayW'($urandom_range(1, 31));
    r.hour = HourW'($urandom_range(0, 23));
    r.minute = MinW'($urandom_range(0, 63));
    r.second = SecW'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 33) begin
      r.command = CMD_HOURS;
      r.delta = ($urandom_range(0, 9) == 0) ? DeltaW'($urandom)
                                           : DeltaW'(int'($urandom_range(0, 46)) - 23);
    end else if (pick < 66) begin
      r.command = CMD_DAYS;
      case ($urandom_range(0, 19))
        0: r.delta = DeltaW'($urandom);
        1, 2, 3, 4: r.delta = DeltaW'($urandom_range(0, MaxDayDelta));
        default: r.delta = DeltaW'(int'($urandom_range(0, 57)) - 27);
      endcase
    end else if (pick < 96) begin
      r.command = CMD_MONTHS;
      r.delta = ($urandom_range(0, 9) == 0) ? DeltaW'($urandom)
                                           : DeltaW'(int'($urandom_range(0, 22)) - 11);
    end else begin
      r.command = CmdUnknown;
      r.delta = DeltaW'($urandom);
    end
    return r;
  endfunction

  // send one request; valid stays high until the caller goes idle
  task automatic send_req(shift_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= r.command;
    s_axis_tdata_i <= {7'd0, r.delta, r.second, r.minute, r.hour, r.day, r.month, r.year};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_stamps.push_back(shift_stamp(r));
  endtask

  task automatic send_random(int count);
    repeat (count) send_req(random_req());
  endtask

  // receiver ready, with random stalls and an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_off_seen != hold_off_seq) begin
      hold_off_seen <= hold_off_seq;
      hold_off_left <= hold_off_len;
      m_axis_tready_i <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    shifted_stamp_t exp_stamp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_stamps.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        exp_stamp = pending_stamps.pop_front();
        check_field("year", exp_stamp.year, m_axis_tdata_o[13:0]);
        check_field("month", exp_stamp.month, m_axis_tdata_o[17:14]);
        check_field("day", exp_stamp.day, m_axis_tdata_o[22:18]);
        check_field("hour", exp_stamp.hour, m_axis_tdata_o[27:23]);
        check_field("minute", exp_stamp.minute, m_axis_tdata_o[33:28]);
        check_field("second", exp_stamp.second, m_axis_tdata_o[39:34]);
        check_field("range_error", exp_stamp.range_error, m_axis_tuser_o);
      end
    end
  end

  // range edges, bad timestamps, leap rules and carries
  task automatic test_directed_cases();
    send_req(make_req(CMD_HOURS, 2023, 12, 31, 23, 0, 0, 23));
    send_req(make_req(CMD_HOURS, 0, 1, 1, 0, 59, 59, -23));
    send_req(make_req(CMD_HOURS, 2020, 6, 15, 12, 1, 2, 24));
    send_req(make_req(CMD_HOURS, 2020, 6, 15, 12, 1, 2, -24));
    send_req(make_req(CMD_DAYS, 2024, 1, 1, 5, 30, 30, MaxDayDelta));
    send_req(make_req(CMD_DAYS, 2024, 3, 1, 5, 30, 30, -27));
    send_req(make_req(CMD_DAYS, 2024, 3, 1, 5, 30, 30, -28));
    send_req(make_req(CMD_DAYS, 2024, 3, 1, 5, 30, 30, -256));
    send_req(make_req(CMD_MONTHS, 9999, 1, 15, 7, 0, 0, 11));
    send_req(make_req(CMD_MONTHS, 2000, 5, 15, 7, 0, 0, 12));
    send_req(make_req(CMD_MONTHS, 0, 11, 5, 7, 0, 0, -11));
    send_req(make_req(CMD_MONTHS, 2000, 5, 15, 7, 0, 0, -12));
    send_req(make_req(CMD_MONTHS, 9999, 12, 31, 23, 0, 0, 1));
    send_req(make_req(CmdUnknown, 2000, 5, 15, 7, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 10000, 5, 15, 7, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 16383, 15, 31, 31, 63, 63, 1));
    send_req(make_req(CMD_HOURS, 2000, 0, 15, 7, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 2000, 5, 0, 7, 0, 0, 1));
    send_req(make_req(CMD_MONTHS, 2000, 5, 15, 24, 0, 0, 1));
    // day past month end is accepted and wraps
    send_req(make_req(CMD_DAYS, 2021, 2, 31, 0, 0, 0, 1));
    // leap rules: every 400, not every 100, year zero
    send_req(make_req(CMD_DAYS, 2000, 2, 28, 0, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 1900, 2, 28, 0, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 0, 2, 28, 0, 0, 0, 1));
    send_req(make_req(CMD_DAYS, 9999, 12, 31, 23, 63, 63, 0));
    send_req(make_req(CMD_DAYS, 9999, 12, 25, 0, 17, 42, 10));
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(PhaseItems);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 52;
    recv_stall_pct = 0;
    send_random(PhaseItems);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    send_random(PhaseItems);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic test_both_idle();
    send_idle_pct = 35;
    recv_stall_pct = 35;
    send_random(PhaseItems);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // output held off while input keeps coming, so the block backs up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_len = HoldOffCycles;
    hold_off_seq++;
    send_random(PhaseItems);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold_off();
    while (pending_stamps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
